### rtl/assert_macros.svh
// Assertion macros used by qss_weighted_sum
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent at the same edge
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent at the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/qss_pkg.sv
// ----------------------------------------------------------------------------
// qss_pkg
// Shared types and constants of the quantized-state weighted sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package qss_pkg;
    localparam int NUM_INPUTS = 8;
    localparam int PORTS      = 8;
    localparam int PW         = 3;

    localparam logic [1:0] ORDER_ONE   = 2'd1;
    localparam logic [1:0] ORDER_TWO   = 2'd2;
    localparam logic [1:0] ORDER_THREE = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_WB,
        ST_G1,
        ST_G2,
        ST_G3,
        ST_NEXT,
        ST_OUT
    } t_state;

    // one coefficient triple of a port
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] slope;
        logic signed [31:0] curve;
    } t_coef;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) r = 32'sh7fffffff;
        else if (v < -66'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction
endpackage
`default_nettype wire

### rtl/qss_ram.sv
// ----------------------------------------------------------------------------
// qss_ram
// Coefficient store: one write and one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module qss_ram (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [2:0]           i_waddr,
    input  wire qss_pkg::t_coef       i_wdata,
    input  wire logic [2:0]           i_raddr,
    output qss_pkg::t_coef            o_rdata
);
    import qss_pkg::*;
    t_coef r_mem [PORTS];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/qss_mul.sv
// ----------------------------------------------------------------------------
// qss_mul
// Registered signed 33x33 multiplier with floor shift by 16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module qss_mul (
    input  wire logic               i_clk,
    input  wire logic signed [32:0] i_a,
    input  wire logic signed [32:0] i_b,
    output logic signed [49:0]      o_p
);
    logic signed [65:0] w_p;
    assign w_p = i_a * i_b;
    // arithmetic shift floors toward minus infinity
    always_ff @(posedge i_clk) begin
        o_p <= w_p[65:16];
    end
endmodule
`default_nettype wire

### rtl/qss_weighted_sum.sv
// ----------------------------------------------------------------------------
// qss_weighted_sum
// Quantized-state weighted sum of up to eight polynomial trajectories.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// s_axis   in   tdata: port[2:0] value_in[34:3] slope_in[66:35] curve_in[98:67]
//               elapsed[129:99]
// m_axis   out  tdata: sum_value[31:0] sum_slope[63:32] sum_curve[95:64]
//               order_out[97:96]
// cfg      in   i_cfg_we, i_cfg_idx (gain index), i_cfg_data (Q16.16 gain)
//
// Sequencing: the single shared multiplier serves the ports in turn, with three
// products per port for advance plus three for the gain sums, each taken
// through its output register.
// Reset: synchronous, active low; sets order to one, clears gains and sweeps
// the store clear before the first request is taken.
// Stalls: the result waits in the output register; the next request is taken
// once the output register is free again.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module qss_weighted_sum (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // port, value_in, slope_in, curve_in, elapsed (lowest bit up)
    input  wire logic [135:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // sum_value, sum_slope, sum_curve, order_out (lowest bit up)
    output logic [103:0]      m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [31:0]  i_cfg_data
);
    import qss_pkg::*;

    t_state r_st, n_st;
    logic [1:0] r_ord;
    logic [PW-1:0] r_port, r_i;
    logic [3:0] r_clr;
    logic signed [31:0] r_v, r_s, r_c;
    logic [30:0] r_e;
    logic signed [31:0] r_gain [PORTS];
    logic signed [65:0] r_acc0, r_acc1, r_acc2;
    logic signed [65:0] r_nv, r_ns;
    t_coef r_cur;
    logic [103:0] r_out;
    logic r_ov;

    // store ports
    logic w_we;
    logic [2:0] w_waddr;
    t_coef w_wdata, w_rdata;

    // multiplier operands
    logic signed [32:0] w_ma, w_mb;
    logic signed [49:0] w_mp;

    qss_mul u_mul (.i_clk(i_clk), .i_a(w_ma), .i_b(w_mb), .o_p(w_mp));
    qss_ram u_ram (.i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
                   .i_raddr(r_i), .o_rdata(w_rdata));

    logic w_acc_in, w_last, w_adv;
    assign w_acc_in = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_st == ST_IDLE) && (r_clr == 4'd8) && !r_ov;
    assign w_last = (r_i == 3'(NUM_INPUTS - 1));
    // advance other ports only in order two and three
    assign w_adv = (r_ord != ORDER_ONE) && (r_i != r_port);

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (w_acc_in) n_st = ST_RD;
            ST_RD:   n_st = ST_M1;
            ST_M1:   n_st = ST_M2;
            ST_M2:   n_st = ST_M3;
            ST_M3:   n_st = ST_M4;
            ST_M4:   n_st = ST_WB;
            ST_WB:   n_st = ST_G1;
            ST_G1:   n_st = ST_G2;
            ST_G2:   n_st = ST_G3;
            ST_G3:   n_st = ST_NEXT;
            ST_NEXT: n_st = w_last ? ST_OUT : ST_RD;
            ST_OUT:  n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    // multiplier operand select; the entry is on the read port during M1,
    // and curve*e feeds straight back, clamped, for the curve*e*e term
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_st)
            ST_M1: begin w_ma = 33'(w_rdata.slope); w_mb = {2'b00, r_e}; end
            ST_M2: begin w_ma = 33'(r_cur.curve); w_mb = {2'b00, r_e}; end
            ST_M3: begin w_ma = 33'(sat32(66'(w_mp))); w_mb = {2'b00, r_e}; end
            ST_WB: begin w_ma = 33'(r_gain[r_i]); w_mb = 33'(w_wdata.value); end
            ST_G1: begin w_ma = 33'(r_gain[r_i]); w_mb = 33'(r_cur.slope); end
            ST_G2: begin w_ma = 33'(r_gain[r_i]); w_mb = 33'(r_cur.curve); end
            default: ;
        endcase
    end

    // write-back entry for the port in hand, or a zero entry during the reset sweep
    always_comb begin
        w_we = 1'b0;
        w_waddr = r_i;
        w_wdata = r_cur;
        if (r_clr != 4'd8) begin
            w_we = 1'b1;
            w_waddr = r_clr[2:0];
            w_wdata = '0;
        end else if (r_st == ST_WB) begin
            w_we = 1'b1;
            if (r_i == r_port) begin
                w_wdata.value = r_v;
                if (r_ord == ORDER_ONE) begin
                    if (r_s != 0) w_wdata.slope = r_s;
                    if (r_c != 0) w_wdata.curve = r_c;
                end else if (r_ord == ORDER_TWO) begin
                    w_wdata.slope = r_s;
                    if (r_c != 0) w_wdata.curve = r_c;
                end else begin
                    w_wdata.slope = r_s;
                    w_wdata.curve = r_c;
                end
            end else if (w_adv) begin
                w_wdata.value = sat32(r_nv);
                if (r_ord == ORDER_THREE) w_wdata.slope = sat32(r_ns);
            end
        end
    end

    // order after this request; the sweep keeps the order it started with
    logic [1:0] w_ord_new;
    always_comb begin
        w_ord_new = r_ord;
        if (r_ord == ORDER_ONE && r_s != 0) w_ord_new = ORDER_TWO;
        if (r_ord != ORDER_THREE && r_c != 0) w_ord_new = ORDER_THREE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ord <= ORDER_ONE;
            r_clr <= '0;
            r_ov <= 1'b0;
            r_i <= '0;
            for (int k = 0; k < PORTS; k++) r_gain[k] <= '0;
        end else begin
            r_st <= n_st;
            if (r_clr != 4'd8) r_clr <= r_clr + 4'd1;
            if (i_cfg_we) r_gain[i_cfg_idx] <= i_cfg_data;
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            case (r_st)
                ST_IDLE: if (w_acc_in) begin
                    r_port <= s_axis_tdata[2:0];
                    r_v <= s_axis_tdata[34:3];
                    r_s <= s_axis_tdata[66:35];
                    r_c <= s_axis_tdata[98:67];
                    r_e <= s_axis_tdata[129:99];
                    r_i <= '0;
                    r_acc0 <= '0;
                    r_acc1 <= '0;
                    r_acc2 <= '0;
                end
                ST_M1: r_cur <= w_rdata;
                // slope*e is out of the multiplier
                ST_M2: r_nv <= 66'(r_cur.value) + 66'(w_mp);
                // curve*e is out of the multiplier
                ST_M3: r_ns <= 66'(r_cur.slope) + 66'(w_mp) + 66'(w_mp);
                ST_M4: r_nv <= r_nv + ((r_ord == ORDER_THREE) ? 66'(w_mp) : 66'sd0);
                ST_WB: begin
                    if (r_ord != ORDER_THREE) r_ns <= 66'(r_cur.slope);
                    r_cur <= w_wdata;
                end
                ST_G1: r_acc0 <= r_acc0 + 66'(w_mp);
                ST_G2: r_acc1 <= r_acc1 + 66'(w_mp);
                ST_G3: r_acc2 <= r_acc2 + 66'(w_mp);
                ST_NEXT: if (!w_last) r_i <= r_i + 3'd1;
                ST_OUT: begin
                    r_ord <= w_ord_new;
                    r_out <= {6'd0, w_ord_new,
                              (w_ord_new == ORDER_THREE) ? sat32(r_acc2) : 32'sd0,
                              (w_ord_new != ORDER_ONE) ? sat32(r_acc1) : 32'sd0,
                              sat32(r_acc0)};
                    r_ov <= 1'b1;
                    r_i <= '0;
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_out;

    `ASSERT_IMPLY(a_no_accept_busy, i_clk, i_rst_n, r_st != ST_IDLE, !s_axis_tready, "accept while busy")
    `ASSERT_ALWAYS(a_order_range, i_clk, i_rst_n, r_ord != 2'd0, "order out of range")
    `ASSERT_NEXT(a_out_valid, i_clk, i_rst_n, r_st == ST_OUT, r_ov, "result lost")
endmodule
`default_nettype wire
